// ===== rtl/h2r_pkg.sv =====
// Shared widths and constants for the HSV to RGB pixel converter.
// Used by the stream interfaces, the rounding scaler and the top level.
// No dependencies.
package h2r_pkg;

  // Field widths
  localparam int HUE_W  = 9;
  localparam int FRAC_W = 8;
  localparam int CH_W   = 8;

  // Angle and fraction constants
  localparam int SECTOR_DEG = 60;
  localparam int FULL_DEG   = 360;
  localparam int FULL_FRAC  = 255;

  // Each channel level is num / DEN, with DEN = 255 * 60
  localparam int DEN  = FULL_FRAC * SECTOR_DEG;
  localparam int DEN2 = 2 * DEN;

  // Widths of the intermediate products
  localparam int D_W    = 6;   // 60 - ramp position, 0..60
  localparam int SD_W   = 14;  // sat * d, up to 15300
  localparam int PB_W   = 16;  // val * (255 - sat)
  localparam int MID_W  = 22;  // val * (15300 - sat * d)
  localparam int N_W    = 23;  // 2 * num + DEN, below 2^23
  localparam int QUO_W  = 9;   // quotient before the clamp

  // Reciprocal of 2 * DEN: floor(n * K / 2^S) equals floor(n / 2*DEN) for all n < 2^N_W
  localparam int RECIP_SHIFT = 38;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_K =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DEN2) - 64'd1) / 64'(DEN2));

endpackage

// ===== rtl/h2r_if.sv =====
// Valid/ready stream interfaces for HSV input words and RGB result words.
// Depends on h2r_pkg for the field widths.
interface h2r_hsv_if;
  import h2r_pkg::*;

  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue_deg;
  logic [FRAC_W-1:0] sat_frac;
  logic [FRAC_W-1:0] val_frac;

  modport source (output valid, output hue_deg, output sat_frac, output val_frac,
                  input ready);
  modport sink   (input valid, input hue_deg, input sat_frac, input val_frac,
                  output ready);
endinterface

interface h2r_rgb_if;
  import h2r_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

// ===== rtl/h2r_scale.sv =====
// Rounding scaler: q = min(255, floor(n / (2*255*60))) by reciprocal multiply.
// Registered output with load enable. Depends on h2r_pkg.
module h2r_scale (
  input  logic                      clk,
  input  logic                      en,
  input  logic [h2r_pkg::N_W-1:0]   n_in,
  output logic [h2r_pkg::CH_W-1:0]  q_out
);
  import h2r_pkg::*;

  localparam int PROD_W = N_W + RECIP_W;

  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo;
  logic [CH_W-1:0]   q_nxt;
  logic [CH_W-1:0]   q_r;

  // Reciprocal multiply, then clamp to the channel range
  always_comb begin
    prod  = PROD_W'(n_in) * PROD_W'(RECIP_K);
    quo   = prod[RECIP_SHIFT +: QUO_W];
    q_nxt = (quo > QUO_W'(FULL_FRAC)) ? CH_W'(FULL_FRAC) : quo[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_out = q_r;

endmodule

// ===== rtl/hsv_to_rgb_pixel.sv =====
// HSV to RGB pixel converter, top level: five-stage pipeline with per-stage stall.
// Depends on h2r_pkg, h2r_if (h2r_hsv_if, h2r_rgb_if) and h2r_scale.
//
// Converts one pixel per clock while the output takes words: hue in whole degrees
// (360..511 wrap by 360), saturation and value as 8-bit fractions with 255 meaning
// 1.0, to 8-bit red, green and blue rounded to nearest. Every stage is fully
// pipelined, so the sustained rate is one word per cycle while the output is ready.
// Stages: hue sector decode, the two 8-bit products, the value multiply for the
// ramp level, the reciprocal-multiply rounding, and the output select register.
// Each stage holds its word while the one after it is full and held, and empty
// stages fill even when the output stalls, so in_ch.ready drops only once all five
// stages hold words.
module hsv_to_rgb_pixel (
  input  logic      clk,
  input  logic      rst_n,
  h2r_hsv_if.sink   in_ch,
  h2r_rgb_if.source out_ch
);
  import h2r_pkg::*;

  // Sector codes
  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;

  // Stage valid bits and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_ch.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // Stage 1: wrap hue, find sector and distance of the ramp from its top
  logic [HUE_W-1:0]  hue_w, base, hue_off;
  logic [2:0]        sect_nxt;
  logic [D_W-1:0]    d_nxt;
  logic [2:0]        sect1_r;
  logic [D_W-1:0]    d1_r;
  logic [FRAC_W-1:0] sat1_r, val1_r;

  always_comb begin
    hue_w = (in_ch.hue_deg >= HUE_W'(FULL_DEG)) ? in_ch.hue_deg - HUE_W'(FULL_DEG)
                                                : in_ch.hue_deg;
    if (hue_w >= HUE_W'(5 * SECTOR_DEG)) begin
      sect_nxt = SEC_5;
      base     = HUE_W'(5 * SECTOR_DEG);
    end else if (hue_w >= HUE_W'(4 * SECTOR_DEG)) begin
      sect_nxt = SEC_4;
      base     = HUE_W'(4 * SECTOR_DEG);
    end else if (hue_w >= HUE_W'(3 * SECTOR_DEG)) begin
      sect_nxt = SEC_3;
      base     = HUE_W'(3 * SECTOR_DEG);
    end else if (hue_w >= HUE_W'(2 * SECTOR_DEG)) begin
      sect_nxt = SEC_2;
      base     = HUE_W'(2 * SECTOR_DEG);
    end else if (hue_w >= HUE_W'(SECTOR_DEG)) begin
      sect_nxt = SEC_1;
      base     = HUE_W'(SECTOR_DEG);
    end else begin
      sect_nxt = SEC_0;
      base     = '0;
    end
    hue_off = hue_w - base;
    // rising ramp in even sectors, falling in odd ones
    d_nxt = sect_nxt[0] ? hue_off[D_W-1:0] : D_W'(SECTOR_DEG) - hue_off[D_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sect1_r <= sect_nxt;
      d1_r    <= d_nxt;
      sat1_r  <= in_ch.sat_frac;
      val1_r  <= in_ch.val_frac;
    end
  end

  // Stage 2: sat * d for the ramp, val * (255 - sat) for the floor level
  logic [SD_W-1:0]   sd2_r;
  logic [PB_W-1:0]   pb2_r;
  logic [FRAC_W-1:0] val2_r;
  logic [2:0]        sect2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      sd2_r   <= SD_W'(sat1_r) * SD_W'(d1_r);
      pb2_r   <= PB_W'(val1_r) * PB_W'(FRAC_W'(FULL_FRAC) - sat1_r);
      val2_r  <= val1_r;
      sect2_r <= sect1_r;
    end
  end

  // Stage 3: ramp level numerator, both levels biased for rounding
  logic [MID_W-1:0]  mid_num;
  logic [N_W-1:0]    n_mid_nxt, n_bot_nxt;
  logic [N_W-1:0]    n_mid3_r, n_bot3_r;
  logic [FRAC_W-1:0] val3_r;
  logic [2:0]        sect3_r;

  always_comb begin
    mid_num   = MID_W'(val2_r) * MID_W'(SD_W'(DEN) - sd2_r);
    n_mid_nxt = {mid_num, 1'b0} + N_W'(DEN);
    n_bot_nxt = N_W'(pb2_r) * N_W'(2 * SECTOR_DEG) + N_W'(DEN);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      n_mid3_r <= n_mid_nxt;
      n_bot3_r <= n_bot_nxt;
      val3_r   <= val2_r;
      sect3_r  <= sect2_r;
    end
  end

  // Stage 4: round to 8 bits
  logic [CH_W-1:0]   q_mid4, q_bot4;
  logic [FRAC_W-1:0] val4_r;
  logic [2:0]        sect4_r;

  h2r_scale u_scale_mid (
    .clk   (clk),
    .en    (en4),
    .n_in  (n_mid3_r),
    .q_out (q_mid4)
  );

  h2r_scale u_scale_bot (
    .clk   (clk),
    .en    (en4),
    .n_in  (n_bot3_r),
    .q_out (q_bot4)
  );

  always_ff @(posedge clk) begin
    if (en4) begin
      val4_r  <= val3_r;
      sect4_r <= sect3_r;
    end
  end

  // Stage 5: place top, ramp and floor levels by sector
  logic [CH_W-1:0] top4;
  logic [CH_W-1:0] r_nxt, g_nxt, b_nxt;
  logic [CH_W-1:0] r5_r, g5_r, b5_r;

  assign top4 = CH_W'(val4_r);

  always_comb begin
    unique case (sect4_r)
      SEC_0:   begin r_nxt = top4;   g_nxt = q_mid4; b_nxt = q_bot4; end
      SEC_1:   begin r_nxt = q_mid4; g_nxt = top4;   b_nxt = q_bot4; end
      SEC_2:   begin r_nxt = q_bot4; g_nxt = top4;   b_nxt = q_mid4; end
      SEC_3:   begin r_nxt = q_bot4; g_nxt = q_mid4; b_nxt = top4;   end
      SEC_4:   begin r_nxt = q_mid4; g_nxt = q_bot4; b_nxt = top4;   end
      default: begin r_nxt = top4;   g_nxt = q_bot4; b_nxt = q_mid4; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      r5_r <= r_nxt;
      g5_r <= g_nxt;
      b5_r <= b_nxt;
    end
  end

  assign out_ch.valid     = v5_r;
  assign out_ch.red_out   = r5_r;
  assign out_ch.green_out = g5_r;
  assign out_ch.blue_out  = b5_r;

  // Assertions
  // ramp level always lies between the floor and the top level
  a_level_order: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (q_bot4 <= q_mid4) && (q_mid4 <= top4))
    else $error("ramp level outside floor..top range");

  // a held stage keeps its word while the next one is full
  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !en4) |=> v3_r && $stable(n_mid3_r) && $stable(n_bot3_r))
    else $error("stage 3 word lost during stall");

  // input is refused only with every stage full and the output stalled
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> v1_r && v2_r && v3_r && v4_r && v5_r && !out_ch.ready)
    else $error("input refused with a free stage");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

// ===== verif/hsv_rgb_check.sv =====
// Checker for the HSV to RGB pixel converter: watches both streams, predicts each pixel.
// Depends on h2r_pkg and the h2r_hsv_if / h2r_rgb_if stream interfaces.
`timescale 1ns / 1ps

module hsv_rgb_check (
  input  logic clk,
  input  logic rst_n,
  h2r_hsv_if   hsv_mon,
  h2r_rgb_if   rgb_mon,
  output int   mismatches,
  output int   pixels_checked,
  output int   pixels_pending
);
  import h2r_pkg::*;

  // Hue sectors, named by the colors they span
  typedef enum int unsigned {
    SEC_RED_YELLOW,
    SEC_YELLOW_GREEN,
    SEC_GREEN_CYAN,
    SEC_CYAN_BLUE,
    SEC_BLUE_MAGENTA,
    SEC_MAGENTA_RED
  } hue_sector_e;

  // One expected pixel, with the input word kept for messages
  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] val;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
  } rgb_expect_t;

  rgb_expect_t rgb_pending[$];
  rgb_expect_t oldest_rgb;

  // Level num / (255*60) to 8 bits: round half up, clamp to full scale
  function automatic logic [CH_W-1:0] round_channel(input int unsigned num);
    int unsigned q;
    q = (2 * num + DEN) / DEN2;
    if (q > FULL_FRAC) q = FULL_FRAC;
    return q[CH_W-1:0];
  endfunction

  function automatic rgb_expect_t hsv_to_rgb_predict(input logic [HUE_W-1:0] hue_in,
                                                     input logic [FRAC_W-1:0] sat,
                                                     input logic [FRAC_W-1:0] val);
    rgb_expect_t e;
    int unsigned hue, hue_off, ramp, top, bot, mid, r, g, b;
    int unsigned s, v;
    hue_sector_e sector;
    s = sat;
    v = val;
    hue = hue_in;
    // hue is an angle: 360..511 folds back onto 0..151
    if (hue >= FULL_DEG) hue = hue - FULL_DEG;
    sector = hue_sector_e'(hue / SECTOR_DEG);
    hue_off = hue % SECTOR_DEG;
    // ramp rises through even sectors, falls through odd ones
    ramp = (int'(sector) % 2 == 1) ? SECTOR_DEG - hue_off : hue_off;
    top = v * DEN;
    bot = v * (FULL_FRAC - s) * SECTOR_DEG;
    mid = v * (DEN - s * (SECTOR_DEG - ramp));
    case (sector)
      SEC_RED_YELLOW: begin
        r = top; g = mid; b = bot;
      end
      SEC_YELLOW_GREEN: begin
        r = mid; g = top; b = bot;
      end
      SEC_GREEN_CYAN: begin
        r = bot; g = top; b = mid;
      end
      SEC_CYAN_BLUE: begin
        r = bot; g = mid; b = top;
      end
      SEC_BLUE_MAGENTA: begin
        r = mid; g = bot; b = top;
      end
      default: begin
        r = top; g = bot; b = mid;
      end
    endcase
    e.hue   = hue_in;
    e.sat   = sat;
    e.val   = val;
    e.red   = round_channel(r);
    e.green = round_channel(g);
    e.blue  = round_channel(b);
    return e;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_channel(input string name, input logic [CH_W-1:0] got,
                               input logic [CH_W-1:0] want, input rgb_expect_t e);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d (h=%0d s=%0d v=%0d)",
                                name, got, want, e.hue, e.sat, e.val));
  endtask

  // Predict on input accept, compare on output accept; counts clear in reset
  always @(posedge clk) begin
    if (!rst_n) begin
      mismatches     = 0;
      pixels_checked = 0;
    end else begin
      if (hsv_mon.valid && hsv_mon.ready)
        rgb_pending.push_back(hsv_to_rgb_predict(hsv_mon.hue_deg, hsv_mon.sat_frac,
                                                 hsv_mon.val_frac));
      if (rgb_mon.valid && rgb_mon.ready) begin
        if (rgb_pending.size() == 0) begin
          report_mismatch($sformatf("unexpected word r=%0d g=%0d b=%0d",
                                    rgb_mon.red_out, rgb_mon.green_out, rgb_mon.blue_out));
        end else begin
          oldest_rgb = rgb_pending.pop_front();
          check_channel("red",   rgb_mon.red_out,   oldest_rgb.red,   oldest_rgb);
          check_channel("green", rgb_mon.green_out, oldest_rgb.green, oldest_rgb);
          check_channel("blue",  rgb_mon.blue_out,  oldest_rgb.blue,  oldest_rgb);
          pixels_checked++;
        end
      end
    end
    pixels_pending = rgb_pending.size();
  end

endmodule

// ===== verif/tb.sv =====
// Top of the HSV to RGB pixel converter bench: clock, reset, stimulus, verdict.
// Depends on h2r_pkg, the stream interfaces, hsv_to_rgb_pixel and hsv_rgb_check.
`timescale 1ns / 1ps

module tb;
  import h2r_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_WORDS  = 100;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 10;

  logic clk;
  logic rst_n;

  h2r_hsv_if hsv_ch ();
  h2r_rgb_if rgb_ch ();

  int mismatches;
  int pixels_checked;
  int pixels_pending;

  int send_idle_pct;
  int recv_stall_pct;
  int words_sent;
  int wrapped_hues;
  int cycle_count = 0;
  logic hold_off;

  hsv_to_rgb_pixel i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (hsv_ch),
    .out_ch (rgb_ch)
  );

  hsv_rgb_check i_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .hsv_mon        (hsv_ch),
    .rgb_mon        (rgb_ch),
    .mismatches     (mismatches),
    .pixels_checked (pixels_checked),
    .pixels_pending (pixels_pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: random stalls, forced low during the hold-off
  always @(negedge clk)
    rgb_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

  // Long receiver hold-off while the sender keeps offering, fills the pipe
  initial begin
    hold_off = 1'b0;
    wait (words_sent >= 30);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Offer one HSV word, with a random gap first; returns at the next falling edge
  task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [FRAC_W-1:0] sat,
                            input logic [FRAC_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      hsv_ch.valid <= 1'b0;
      @(negedge clk);
    end
    hsv_ch.valid    <= 1'b1;
    hsv_ch.hue_deg  <= hue;
    hsv_ch.sat_frac <= sat;
    hsv_ch.val_frac <= val;
    @(posedge clk);
    while (!hsv_ch.ready) @(posedge clk);
    words_sent++;
    if (hue >= FULL_DEG) wrapped_hues++;
    @(negedge clk);
  endtask

  // Fractions lean on the ends of the range now and then
  function automatic logic [FRAC_W-1:0] pick_frac();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  int send_pct[4]  = '{0, 64, 0, 7};
  int stall_pct[4] = '{0, 0, 64, 7};

  initial begin
    logic [HUE_W-1:0] hue;
    rst_n           = 1'b0;
    hsv_ch.valid    = 1'b0;
    hsv_ch.hue_deg  = '0;
    hsv_ch.sat_frac = '0;
    hsv_ch.val_frac = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    words_sent      = 0;
    wrapped_hues    = 0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: sector edges, ramp both ways, wrapped hues, zero and full S / V
    send_pixel(9'd0,   8'd255, 8'd255);
    send_pixel(9'd59,  8'd255, 8'd255);
    send_pixel(9'd60,  8'd255, 8'd255);
    send_pixel(9'd61,  8'd200, 8'd255);
    send_pixel(9'd119, 8'd255, 8'd255);
    send_pixel(9'd120, 8'd255, 8'd128);
    send_pixel(9'd150, 8'd100, 8'd200);
    send_pixel(9'd180, 8'd255, 8'd255);
    send_pixel(9'd210, 8'd77,  8'd190);
    send_pixel(9'd240, 8'd255, 8'd255);
    send_pixel(9'd270, 8'd1,   8'd254);
    send_pixel(9'd300, 8'd255, 8'd255);
    send_pixel(9'd330, 8'd128, 8'd1);
    send_pixel(9'd359, 8'd255, 8'd255);
    send_pixel(9'd360, 8'd255, 8'd255);
    send_pixel(9'd420, 8'd180, 8'd90);
    send_pixel(9'd479, 8'd255, 8'd255);
    send_pixel(9'd511, 8'd255, 8'd255);
    send_pixel(9'd90,  8'd0,   8'd173);
    send_pixel(9'd200, 8'd0,   8'd255);
    send_pixel(9'd45,  8'd255, 8'd0);
    send_pixel(9'd333, 8'd0,   8'd0);
    send_pixel(9'd30,  8'd128, 8'd128);

    // Random words in four idling phases
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_pct[p];
      recv_stall_pct = stall_pct[p];
      repeat (PHASE_WORDS) begin
        if ($urandom_range(7) == 0) hue = HUE_W'($urandom_range(511, FULL_DEG));
        else                        hue = HUE_W'($urandom_range(FULL_DEG - 1));
        send_pixel(hue, pick_frac(), pick_frac());
      end
    end
    hsv_ch.valid <= 1'b0;

    // Drain: everything predicted must come out
    wait (pixels_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d pixels (%0d with wrapped hue) over four idling phases",
             pixels_checked, wrapped_hues);
    $display("output held off %0d cycles once to back up the pipe", HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
